@@ src/wpsf_pkg.sv @@
// ----------------------------------------------------------------------------
// wpsf_pkg
// Shared types, constants and the arctangent table for the wrapped phase
// pipeline.
// ----------------------------------------------------------------------------
package wpsf_pkg;

    // Field and register widths.
    localparam int SAMPLE_W    = 8;
    localparam int PHASE_W     = 16;
    localparam int THRESH_W    = 13;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Internal datapath widths: the rotated vector stays below 2^25 in magnitude.
    localparam int VEC_W = 27;
    localparam int ANG_W = 24;

    // CORDIC schedule.
    localparam int CORDIC_STEPS      = 18;
    localparam int STEPS_PER_STAGE   = 3;
    localparam int NUM_CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_STEP_MODE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_THRESHOLD  = 8'd1;

    // Angle constants.
    localparam logic signed [PHASE_W-1:0] PHASE_PI_Q13      = 16'sd25736;
    localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [ANG_W-1:0]   HALF_PI_Q20       = 24'sd1647099;
    localparam logic signed [15:0]        ROOT3_Q14         = 16'sd28378;

    // One item as it travels through the rotation stages.
    typedef struct packed {
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [ANG_W-1:0]   z;
        logic                      pix_valid;
        logic                      special;
        logic signed [PHASE_W-1:0] special_phase;
    } vec_t;

    // Rounded atan(2^-step) in Q.20 radians.
    function automatic logic signed [ANG_W-1:0] atan_q20(input int step);
        logic signed [ANG_W-1:0] a;
        case (step)
            0:       a = 24'sd823550;
            1:       a = 24'sd486170;
            2:       a = 24'sd256879;
            3:       a = 24'sd130396;
            4:       a = 24'sd65451;
            5:       a = 24'sd32757;
            6:       a = 24'sd16383;
            7:       a = 24'sd8192;
            8:       a = 24'sd4096;
            9:       a = 24'sd2048;
            10:      a = 24'sd1024;
            11:      a = 24'sd512;
            12:      a = 24'sd256;
            13:      a = 24'sd128;
            14:      a = 24'sd64;
            15:      a = 24'sd32;
            16:      a = 24'sd16;
            17:      a = 24'sd8;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/wpsf_prep.sv @@
// ----------------------------------------------------------------------------
// wpsf_prep
// Two front stages: quadrature pair and squares, then the modulation test,
// the axis cases and the quarter-turn fold into the right half plane.
// ----------------------------------------------------------------------------
module wpsf_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          four_step_mode,
    input  logic [wpsf_pkg::THRESH_W-1:0] modulation_threshold,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wpsf_pkg::SAMPLE_W-1:0] sample_one,
    input  logic [wpsf_pkg::SAMPLE_W-1:0] sample_two,
    input  logic [wpsf_pkg::SAMPLE_W-1:0] sample_three,
    input  logic [wpsf_pkg::SAMPLE_W-1:0] sample_four,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wpsf_pkg::vec_t                out_vec
);
    import wpsf_pkg::*;

    // Stage A registers.
    logic                         a_valid_reg;
    logic                         a_mode_reg,  a_mode_next;
    logic [17:0]                  a_dsq_reg,   a_dsq_next;
    logic [17:0]                  a_esq_reg,   a_esq_next;
    logic [2*THRESH_W-1:0]        a_tsq_reg,   a_tsq_next;
    logic signed [VEC_W-1:0]      a_x_reg,     a_x_next;
    logic signed [VEC_W-1:0]      a_y_reg,     a_y_next;

    // Stage B registers.
    logic                         b_valid_reg;
    vec_t                         b_vec_reg,   b_vec_next;

    logic a_ready, b_ready;

    // A stage takes a new item when it is empty or its item moves on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Stage A: differences, quadrature components and squares.
    always_comb begin
        logic signed [9:0]  i1, i2, i3, i4, d, e;
        logic signed [19:0] dsq_full, esq_full;
        i1 = signed'({2'b00, sample_one});
        i2 = signed'({2'b00, sample_two});
        i3 = signed'({2'b00, sample_three});
        i4 = signed'({2'b00, sample_four});
        if (four_step_mode) begin
            d        = i4 - i2;
            e        = i1 - i3;
            a_y_next = VEC_W'(d) <<< 14;
        end else begin
            d        = i1 - i2;
            e        = (i2 <<< 1) - i1 - i3;
            a_y_next = VEC_W'(d) * VEC_W'(ROOT3_Q14);
        end
        a_x_next    = VEC_W'(e) <<< 14;
        dsq_full    = 20'(d) * 20'(d);
        esq_full    = 20'(e) * 20'(e);
        a_dsq_next  = dsq_full[17:0];
        a_esq_next  = esq_full[17:0];
        a_tsq_next  = (2*THRESH_W)'(modulation_threshold) * (2*THRESH_W)'(modulation_threshold);
        a_mode_next = four_step_mode;
    end

    // Stage B: modulation compare, axis cases and fold.
    always_comb begin
        logic [30:0] lhs, rhs;
        if (a_mode_reg) begin
            lhs = (31'(a_dsq_reg) + 31'(a_esq_reg)) << 6;
            rhs = 31'(a_tsq_reg);
        end else begin
            lhs = (31'(a_dsq_reg) * 31'd3 + 31'(a_esq_reg)) << 10;
            rhs = 31'(a_tsq_reg) * 31'd9;
        end
        b_vec_next.pix_valid = (lhs >= rhs);

        // A vector on an axis gets its angle directly.
        b_vec_next.special = (a_y_reg == '0) || (a_x_reg == '0);
        if (a_y_reg == '0) begin
            b_vec_next.special_phase = (a_x_reg >= 0) ? '0 : PHASE_PI_Q13;
        end else begin
            b_vec_next.special_phase = (a_y_reg > 0) ? PHASE_HALF_PI_Q13
                                                     : -PHASE_HALF_PI_Q13;
        end

        // Left half plane vectors turn by a quarter into the right half.
        if (a_x_reg < 0) begin
            if (a_y_reg >= 0) begin
                b_vec_next.x = a_y_reg;
                b_vec_next.y = -a_x_reg;
                b_vec_next.z = HALF_PI_Q20;
            end else begin
                b_vec_next.x = -a_y_reg;
                b_vec_next.y = a_x_reg;
                b_vec_next.z = -HALF_PI_Q20;
            end
        end else begin
            b_vec_next.x = a_x_reg;
            b_vec_next.y = a_y_reg;
            b_vec_next.z = '0;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers load only with an item.
    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_mode_reg <= a_mode_next;
            a_dsq_reg  <= a_dsq_next;
            a_esq_reg  <= a_esq_next;
            a_tsq_reg  <= a_tsq_next;
            a_x_reg    <= a_x_next;
            a_y_reg    <= a_y_next;
        end
        if (b_ready && a_valid_reg) begin
            b_vec_reg <= b_vec_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_vec   = b_vec_reg;

endmodule

@@ src/wpsf_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// wpsf_cordic_stage
// One register stage of the vectoring CORDIC, running a fixed group of
// consecutive iterations.
// ----------------------------------------------------------------------------
module wpsf_cordic_stage #(
    parameter int FIRST_STEP = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  wpsf_pkg::vec_t in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output wpsf_pkg::vec_t out_vec
);
    import wpsf_pkg::*;

    logic valid_reg;
    vec_t vec_reg, vec_next;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward the x axis, accumulating the angle.
    always_comb begin
        logic signed [VEC_W-1:0] x, y, xs, ys;
        logic signed [ANG_W-1:0] z;
        int                      step;
        vec_next = in_vec;
        x        = in_vec.x;
        y        = in_vec.y;
        z        = in_vec.z;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            step = FIRST_STEP + k;
            xs   = x >>> step;
            ys   = y >>> step;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q20(step);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q20(step);
            end
        end
        vec_next.x = x;
        vec_next.y = y;
        vec_next.z = z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ src/wpsf_finish.sv @@
// ----------------------------------------------------------------------------
// wpsf_finish
// Output stage: rounds the Q.20 angle to Q3.13, clamps it to one half turn,
// applies the axis cases and the invalid flag, and holds the result item.
// ----------------------------------------------------------------------------
module wpsf_finish (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  wpsf_pkg::vec_t                     in_vec,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [wpsf_pkg::PHASE_W-1:0] m_wrapped_phase,
    output logic                               m_phase_valid
);
    import wpsf_pkg::*;

    logic                      valid_reg;
    logic signed [PHASE_W-1:0] phase_reg, phase_next;
    logic                      pvalid_reg;

    assign in_ready = !valid_reg || m_ready;

    // Round to nearest by floor((z + 64) / 128), then clamp.
    always_comb begin
        logic signed [ANG_W:0]   zr;
        logic signed [ANG_W-7:0] r;
        zr = (ANG_W+1)'(in_vec.z) + (ANG_W+1)'(64);
        r  = (ANG_W-6)'(zr >>> 7);
        if (!in_vec.pix_valid) begin
            phase_next = '0;
        end else if (in_vec.special) begin
            phase_next = in_vec.special_phase;
        end else if (r > (ANG_W-6)'(PHASE_PI_Q13)) begin
            phase_next = PHASE_PI_Q13;
        end else if (r < -(ANG_W-6)'(PHASE_PI_Q13)) begin
            phase_next = -PHASE_PI_Q13;
        end else begin
            phase_next = r[PHASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            phase_reg  <= phase_next;
            pvalid_reg <= in_vec.pix_valid;
        end
    end

    assign m_valid         = valid_reg;
    assign m_wrapped_phase = phase_reg;
    assign m_phase_valid   = pvalid_reg;

endmodule

@@ src/wrapped_phase_from_shifted_fringes.sv @@
// ----------------------------------------------------------------------------
// wrapped_phase_from_shifted_fringes
// Wrapped phase and modulation check for one pixel of a three- or four-step
// phase shifted fringe set, as a fully pipelined stream block.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while the output is not stalled and returns
// one result item per pixel, in order: two front stages form the quadrature
// pair and test the modulation against the threshold, six stages each run
// three of the eighteen CORDIC vectoring iterations, and the output register
// rounds and holds the phase. Each stage has its own valid bit and moves
// whenever the stage after it has room, so a stalled output only blocks the
// input once the pipeline has filled. Invalid pixels report phase zero with
// phase_valid low. Configuration registers are written at index 0
// (four_step_mode) and 1 (modulation_threshold); cfg_ready is always high
// and writes to other indexes are dropped. Write them only while no pixel
// is in flight.
module wrapped_phase_from_shifted_fringes (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wpsf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wpsf_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [wpsf_pkg::SAMPLE_W-1:0]         s_sample_one,
    input  logic [wpsf_pkg::SAMPLE_W-1:0]         s_sample_two,
    input  logic [wpsf_pkg::SAMPLE_W-1:0]         s_sample_three,
    input  logic [wpsf_pkg::SAMPLE_W-1:0]         s_sample_four,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [wpsf_pkg::PHASE_W-1:0]   m_wrapped_phase,
    output logic                                  m_phase_valid
);
    import wpsf_pkg::*;

    logic                four_step_mode_reg;
    logic [THRESH_W-1:0] threshold_reg;

    vec_t stage_vec   [NUM_CORDIC_STAGES+1];
    logic stage_valid [NUM_CORDIC_STAGES+1];
    logic stage_ready [NUM_CORDIC_STAGES+1];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_step_mode_reg <= 1'b0;
            threshold_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FOUR_STEP_MODE: four_step_mode_reg <= cfg_data[0];
                REG_MOD_THRESHOLD:  threshold_reg      <= cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Front stages.
    wpsf_prep u_prep (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .four_step_mode       (four_step_mode_reg),
        .modulation_threshold (threshold_reg),
        .in_valid             (s_valid),
        .in_ready             (s_ready),
        .sample_one           (s_sample_one),
        .sample_two           (s_sample_two),
        .sample_three         (s_sample_three),
        .sample_four          (s_sample_four),
        .out_valid            (stage_valid[0]),
        .out_ready            (stage_ready[0]),
        .out_vec              (stage_vec[0])
    );

    // CORDIC stages.
    for (genvar g = 0; g < NUM_CORDIC_STAGES; g++) begin : g_cordic
        wpsf_cordic_stage #(
            .FIRST_STEP (g * STEPS_PER_STAGE)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_vec    (stage_vec[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_vec   (stage_vec[g+1])
        );
    end

    // Output stage.
    wpsf_finish u_finish (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (stage_valid[NUM_CORDIC_STAGES]),
        .in_ready        (stage_ready[NUM_CORDIC_STAGES]),
        .in_vec          (stage_vec[NUM_CORDIC_STAGES]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wrapped_phase (m_wrapped_phase),
        .m_phase_valid   (m_phase_valid)
    );

`ifndef SYNTHESIS
    // An empty output register means every stage can take an item.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready while output register is empty");

    // An invalid pixel always carries phase zero.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_phase_valid) |-> (m_wrapped_phase == '0))
        else $error("invalid pixel with nonzero phase");

    // The reported phase stays within one half turn.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_wrapped_phase <= PHASE_PI_Q13)
                     && (m_wrapped_phase >= -PHASE_PI_Q13)))
        else $error("phase out of range");

    // Nothing comes out in the cycle right after reset.
    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result item right after reset");
`endif

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// wrapped_phase_from_shifted_fringes testbench
// Drives pixel items through the wrapped phase block under random idle gaps on
// both channels and back pressure on the result side. Every accepted pixel is
// run through an independent model of the modulation test and the CORDIC
// arctangent, and each result item is checked field by field, in order.
// Directed corner pixels come first, then random phases that each program the
// step mode and the modulation threshold while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wpsf_pkg::*;

    // The drain covers the whole pipeline with some margin.
    localparam int DRAIN_CYCLES    = 16;
    // Bound on the whole run, far above what the slowest correct run needs.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 170;

    // Indexes with no register behind them; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_FIRST = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LAST  = 8'hFF;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [SAMPLE_W-1:0]          s_sample_one;
    logic [SAMPLE_W-1:0]          s_sample_two;
    logic [SAMPLE_W-1:0]          s_sample_three;
    logic [SAMPLE_W-1:0]          s_sample_four;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [PHASE_W-1:0]    m_wrapped_phase;
    logic                         m_phase_valid;

    // When set, neither side inserts idle cycles.
    bit steady_flow = 1'b0;

    wrapped_phase_from_shifted_fringes dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_one    (s_sample_one),
        .s_sample_two    (s_sample_two),
        .s_sample_three  (s_sample_three),
        .s_sample_four   (s_sample_four),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_wrapped_phase (m_wrapped_phase),
        .m_phase_valid   (m_phase_valid)
    );

    typedef struct packed {
        logic signed [PHASE_W-1:0] phase;
        logic                      valid;
    } pixel_result_t;

    // Predicts the phase of each accepted pixel and checks results in order.
    class fringe_phase_checker;
        localparam int ROOT_THREE_Q14   = 28378;
        localparam int PI_Q13           = 25736;
        localparam int QUARTER_TURN_Q13 = 12868;
        localparam int QUARTER_TURN_Q20 = 1647099;
        localparam int ROTATIONS        = 18;

        bit                  four_step;
        logic [THRESH_W-1:0] threshold;
        pixel_result_t       pending_phases[$];
        int unsigned         errors;
        int                  atan_step_q20[ROTATIONS];

        function new();
            four_step     = 1'b0;
            threshold     = '0;
            errors        = 0;
            atan_step_q20 = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                              8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8};
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == REG_FOUR_STEP_MODE) begin
                four_step = data[0];
            end else if (index == REG_MOD_THRESHOLD) begin
                threshold = data[THRESH_W-1:0];
            end
        endfunction

        // Angle of (x, y) in Q3.13 radians by CORDIC vectoring.
        function logic signed [PHASE_W-1:0] vector_angle(logic signed [31:0] x0,
                                                         logic signed [31:0] y0);
            logic signed [31:0] x, y, xs, ys, swap, z, r;
            x = x0;
            y = y0;
            z = 0;
            // Axis-aligned vectors are answered directly.
            if (y == 0) begin
                if (x >= 0) return '0;
                return PHASE_W'(PI_Q13);
            end
            if (x == 0) begin
                if (y > 0) return PHASE_W'(QUARTER_TURN_Q13);
                return PHASE_W'(-QUARTER_TURN_Q13);
            end
            // Fold the left half plane onto the right by a quarter turn.
            if (x < 0) begin
                swap = x;
                if (y >= 0) begin
                    x = y;
                    y = -swap;
                    z = QUARTER_TURN_Q20;
                end else begin
                    x = -y;
                    y = swap;
                    z = -QUARTER_TURN_Q20;
                end
            end
            for (int i = 0; i < ROTATIONS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_step_q20[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_step_q20[i];
                end
            end
            // Round Q.20 to Q.13 and clamp to plus or minus pi.
            r = (z + 64) >>> 7;
            if (r > PI_Q13) r = PI_Q13;
            if (r < -PI_Q13) r = -PI_Q13;
            return PHASE_W'(r);
        endfunction

        // Forms the quadrature pair, tests the modulation and queues the result.
        function void note_pixel(logic [SAMPLE_W-1:0] s1, logic [SAMPLE_W-1:0] s2,
                                 logic [SAMPLE_W-1:0] s3, logic [SAMPLE_W-1:0] s4);
            logic signed [10:0] i1, i2, i3, i4, d, e;
            logic signed [13:0] thr;
            logic signed [39:0] energy, floor_level;
            logic signed [31:0] x, y;
            pixel_result_t      res;
            i1  = {3'b000, s1};
            i2  = {3'b000, s2};
            i3  = {3'b000, s3};
            i4  = {3'b000, s4};
            thr = {1'b0, threshold};
            if (four_step) begin
                d           = i4 - i2;
                e           = i1 - i3;
                energy      = 64 * (d * d + e * e);
                floor_level = thr * thr;
                y           = d * 16384;
            end else begin
                d           = i1 - i2;
                e           = 2 * i2 - i1 - i3;
                energy      = 1024 * (3 * d * d + e * e);
                floor_level = 9 * thr * thr;
                y           = d * ROOT_THREE_Q14;
            end
            x         = e * 16384;
            res.valid = (energy >= floor_level);
            res.phase = res.valid ? vector_angle(x, y) : '0;
            pending_phases.push_back(res);
        endfunction

        function void check_result(logic signed [PHASE_W-1:0] phase, logic valid);
            pixel_result_t want;
            if (pending_phases.size() == 0) begin
                errors++;
                $display("%0t: result with no pixel pending: phase %0d valid %0b",
                         $time, phase, valid);
                return;
            end
            want = pending_phases.pop_front();
            if (phase !== want.phase) begin
                errors++;
                $display("%0t: wrapped_phase expected %0d actual %0d",
                         $time, want.phase, phase);
            end
            if (valid !== want.valid) begin
                errors++;
                $display("%0t: phase_valid expected %0b actual %0b",
                         $time, want.valid, valid);
            end
        endfunction

        function int outstanding();
            return pending_phases.size();
        endfunction
    endclass

    fringe_phase_checker phase_check;

    // Clock.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int draw_gap();
        if (steady_flow) return 0;
        return $urandom_range(0, 5);
    endfunction

    // Offers one pixel item after a random gap and waits until it is taken.
    task automatic send_pixel(logic [SAMPLE_W-1:0] s1, logic [SAMPLE_W-1:0] s2,
                              logic [SAMPLE_W-1:0] s3, logic [SAMPLE_W-1:0] s4);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_one   <= s1;
        s_sample_two   <= s2;
        s_sample_three <= s3;
        s_sample_four  <= s4;
        do @(posedge aclk); while (!s_ready);
        phase_check.note_pixel(s1, s2, s3, s4);
    endtask

    // Random pixel: flat, saturated, low contrast or uniform samples.
    task automatic send_random_pixel();
        logic [SAMPLE_W-1:0] smp[4];
        int style, base, offs, v;
        style = $urandom_range(0, 9);
        base  = $urandom_range(0, 255);
        for (int k = 0; k < 4; k++) begin
            case (style)
                0: v = base;
                1: v = $urandom_range(0, 1) ? 255 : 0;
                2: begin
                    offs = $urandom_range(0, 16);
                    v    = base + offs - 8;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                default: v = $urandom_range(0, 255);
            endcase
            smp[k] = SAMPLE_W'(v);
        end
        send_pixel(smp[0], smp[1], smp[2], smp[3]);
    endtask

    // Configuration write; valid stays high for back-to-back writes.
    task automatic write_register(logic [CFG_INDEX_W-1:0] index,
                                  logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        phase_check.write_register(index, data);
    endtask

    // Waits until every expected result is back and the pipeline has drained.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (phase_check.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Programs both registers with junk in the unused upper data bits.
    task automatic apply_settings(bit mode, logic [THRESH_W-1:0] thr);
        wait_idle();
        write_register(REG_FOUR_STEP_MODE, {15'($urandom), mode});
        write_register(REG_MOD_THRESHOLD, {3'($urandom), thr});
        if ($urandom_range(0, 2) == 0) begin
            write_register(CFG_INDEX_W'($urandom_range(REG_UNMAPPED_FIRST,
                                                       REG_UNMAPPED_LAST)),
                           16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls before each item.
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        repeat (3) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            phase_check.check_result(m_wrapped_phase, m_phase_valid);
        end
    end

    // Watchdog.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("wrapped_phase_from_shifted_fringes regression: fail");
        $finish;
    end

    // Stimulus.
    initial begin : stimulus
        bit                  mode;
        logic [THRESH_W-1:0] thr;
        phase_check    = new();
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_sample_one   <= '0;
        s_sample_two   <= '0;
        s_sample_three <= '0;
        s_sample_four  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Three-step corners at the reset settings: zero modulation, zero, pi,
        // plus and minus a quarter turn, and the second, third and fourth quadrants.
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd0);
        send_pixel(8'd100, 8'd50, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd50, 8'd100, 8'd0);
        send_pixel(8'd0, 8'd100, 8'd255, 8'd255);

        // Four-step corners.
        apply_settings(1'b1, 13'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd0);

        // Four-step modulation exactly at the threshold, then just below it.
        apply_settings(1'b1, 13'd800);
        send_pixel(8'd100, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd99, 8'd0, 8'd0, 8'd0);

        // Largest threshold rejects even full contrast.
        apply_settings(1'b1, 13'd8191);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd255);

        // Three-step boundary, just below, and the strongest vector.
        apply_settings(1'b0, 13'd1024);
        send_pixel(8'd96, 8'd96, 8'd0, 8'd0);
        send_pixel(8'd95, 8'd95, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255, 8'd0);

        // Random phases; the first four pin the register extremes.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin mode = 1'b0; thr = '0; end
                1: begin mode = 1'b1; thr = '1; end
                2: begin mode = 1'b0; thr = '1; end
                3: begin mode = 1'b1; thr = '0; end
                default: begin
                    mode = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 3) == 0)
                        thr = THRESH_W'($urandom_range(0, 8191));
                    else
                        thr = THRESH_W'($urandom_range(0, mode ? 2900 : 7200));
                end
            endcase
            apply_settings(mode, thr);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
                send_random_pixel();
            end
        end

        wait_idle();
        if (phase_check.errors == 0)
            $display("wrapped_phase_from_shifted_fringes regression: pass");
        else
            $display("wrapped_phase_from_shifted_fringes regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
src/wpsf_pkg.sv
src/wpsf_prep.sv
src/wpsf_cordic_stage.sv
src/wpsf_finish.sv
src/wrapped_phase_from_shifted_fringes.sv
dv/testbench.sv
